FILE: rtl/rbs_pkg.sv
package rbs_pkg;

  // Coordinate format: signed fixed point, CW bits, FB of them fractional
  localparam int CW      = 32;
  localparam int FB      = 16;
  // Exact difference of corner and origin
  localparam int NUMW    = CW + 1;
  // Dividend width: difference magnitude scaled by 2^FB
  localparam int NW      = NUMW + FB;
  // Divider: operand stage, one stage per quotient bit, result stage
  localparam int DIV_LAT = NW + 2;
  // Slab merge: per-axis order, reduction, clamp and hit
  localparam int MRG_LAT = 3;
  localparam int LAT     = DIV_LAT + MRG_LAT;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0]        tenter_t;
  typedef logic [NW-1:0]        quo_t;

  localparam coord_t POS_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t NEG_MIN = {1'b1, {(CW-1){1'b0}}};

endpackage

FILE: rtl/rbs_in_if.sv
interface rbs_in_if;
  import rbs_pkg::*;

  logic   valid;
  logic   ready;
  coord_t origin_x;
  coord_t origin_y;
  coord_t origin_z;
  coord_t dir_x;
  coord_t dir_y;
  coord_t dir_z;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbs_out_if;
  import rbs_pkg::*;

  logic    valid;
  logic    ready;
  tenter_t t_enter;
  coord_t  t_exit;
  logic    hit;

  modport source (output valid, t_enter, t_exit, hit, input ready);
  modport sink   (input valid, t_enter, t_exit, hit, output ready);
endinterface

FILE: rtl/ray_box_slab_intersect.sv
// Ray against axis-aligned box, slab method, signed Q16.16. One ray is
// accepted per cycle while the pipeline is not held, and its result passes
// through the six parallel dividers (operand stage, one stage per quotient
// bit of the 49-bit scaled dividend, saturation stage) and the slab merge.
// The whole pipeline holds while a result waits and out_ch.ready is low.
// Hit is cleared for a ray whose origin lies inside the box.
module ray_box_slab_intersect (
  input  logic clk,
  input  logic rst_n,
  rbs_in_if.sink    in_ch,
  rbs_out_if.source out_ch
);
  import rbs_pkg::*;

  logic   en;
  logic   vld_r [LAT];
  coord_t org [3];
  coord_t dr  [3];
  coord_t lo  [3];
  coord_t hi  [3];
  coord_t t0  [3];
  coord_t t1  [3];

  // Advance everything when the output beat is free or taken
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  assign org = '{in_ch.origin_x, in_ch.origin_y, in_ch.origin_z};
  assign dr  = '{in_ch.dir_x, in_ch.dir_y, in_ch.dir_z};
  assign lo  = '{in_ch.box_min_x, in_ch.box_min_y, in_ch.box_min_z};
  assign hi  = '{in_ch.box_max_x, in_ch.box_max_y, in_ch.box_max_z};

  // Carry valid bits alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_ch.valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbs_div u_div_lo (
      .clk(clk), .en(en), .corner(lo[a]), .origin(org[a]), .dir(dr[a]), .quo(t0[a])
    );
    rbs_div u_div_hi (
      .clk(clk), .en(en), .corner(hi[a]), .origin(org[a]), .dir(dr[a]), .quo(t1[a])
    );
  end

  rbs_merge u_merge (
    .clk(clk), .en(en), .t0(t0), .t1(t1),
    .t_enter(out_ch.t_enter), .t_exit(out_ch.t_exit), .hit(out_ch.hit)
  );

  assign out_ch.valid = vld_r[LAT-1];

endmodule

FILE: rtl/rbs_div.sv
module rbs_div (
  input  logic            clk,
  input  logic            en,
  input  rbs_pkg::coord_t corner,
  input  rbs_pkg::coord_t origin,
  input  rbs_pkg::coord_t dir,
  output rbs_pkg::coord_t quo
);
  import rbs_pkg::*;

  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        nmag;
  logic [CW-1:0]          dmag;

  logic [CW-1:0] r_r   [NW+1];
  quo_t          nq_r  [NW+1];
  logic [CW-1:0] d_r   [NW+1];
  logic          neg_r [NW+1];
  logic          dz_r  [NW+1];
  logic          nn_r  [NW+1];

  quo_t   lim;
  quo_t   q;
  coord_t quo_nxt;
  coord_t quo_r;

  // Form the exact difference and the operand magnitudes
  always_comb begin
    num  = {corner[CW-1], corner} - {origin[CW-1], origin};
    nmag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    dmag = dir[CW-1] ? CW'(-dir) : CW'(dir);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= '0;
      nq_r[0]  <= {nmag, {FB{1'b0}}};
      d_r[0]   <= dmag;
      neg_r[0] <= num[NUMW-1] ^ dir[CW-1];
      dz_r[0]  <= (dir == '0);
      nn_r[0]  <= num[NUMW-1];
    end
  end

  // One quotient bit per stage, restoring
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [CW:0] rs;
    logic        ge;
    logic [CW:0] diff;

    always_comb begin
      rs   = {r_r[k], nq_r[k][NW-1]};
      diff = rs - {1'b0, d_r[k]};
      ge   = (rs >= {1'b0, d_r[k]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= ge ? diff[CW-1:0] : rs[CW-1:0];
        nq_r[k+1]  <= {nq_r[k][NW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        neg_r[k+1] <= neg_r[k];
        dz_r[k+1]  <= dz_r[k];
        nn_r[k+1]  <= nn_r[k];
      end
    end
  end

  // Saturate and restore the sign; a zero direction gives the extreme value of the difference's sign
  always_comb begin
    q   = nq_r[NW];
    lim = neg_r[NW] ? (NW'(1) << (CW-1)) : ((NW'(1) << (CW-1)) - NW'(1));
    if (dz_r[NW]) begin
      quo_nxt = nn_r[NW] ? NEG_MIN : POS_MAX;
    end else if (q > lim) begin
      quo_nxt = neg_r[NW] ? NEG_MIN : POS_MAX;
    end else if (neg_r[NW]) begin
      quo_nxt = coord_t'(~q[CW-1:0] + CW'(1));
    end else begin
      quo_nxt = coord_t'(q[CW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

FILE: rtl/rbs_merge.sv
module rbs_merge (
  input  logic             clk,
  input  logic             en,
  input  rbs_pkg::coord_t  t0 [3],
  input  rbs_pkg::coord_t  t1 [3],
  output rbs_pkg::tenter_t t_enter,
  output rbs_pkg::coord_t  t_exit,
  output logic             hit
);
  import rbs_pkg::*;

  coord_t  mn_r [3];
  coord_t  mx_r [3];
  coord_t  ent_nxt, lv_nxt;
  coord_t  ent_r, lv_r;
  coord_t  ec;
  tenter_t ten_r;
  coord_t  tex_r;
  logic    hit_r;

  // Order the two slab distances per axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        mn_r[a] <= (t0[a] < t1[a]) ? t0[a] : t1[a];
        mx_r[a] <= (t0[a] > t1[a]) ? t0[a] : t1[a];
      end
    end
  end

  // Reduce to entry and exit distances
  always_comb begin
    ent_nxt = (mn_r[0] > mn_r[1]) ? mn_r[0] : mn_r[1];
    ent_nxt = (ent_nxt > mn_r[2]) ? ent_nxt : mn_r[2];
    lv_nxt  = (mx_r[0] < mx_r[1]) ? mx_r[0] : mx_r[1];
    lv_nxt  = (lv_nxt < mx_r[2]) ? lv_nxt : mx_r[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= ent_nxt;
      lv_r  <= lv_nxt;
    end
  end

  // Clamp entry at zero and decide hit
  assign ec = ent_r[CW-1] ? '0 : ent_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ten_r <= ec[CW-2:0];
      tex_r <= lv_r;
      hit_r <= !((lv_r < ec) || (lv_r <= 0) || (ec == '0));
    end
  end

  assign t_enter = ten_r;
  assign t_exit  = tex_r;
  assign hit     = hit_r;

endmodule
